/* src/lbt_pkg.sv */
// Package: shared types, codes and helpers for the listen-before-talk radio MAC.
package lbt_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int DELAY_WIDTH   = 16;
    localparam int SECOND_OFFSET = 25;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_LOOP    = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_NONE     = 2'd0,
        CMD_DETECT   = 2'd1,
        CMD_RECEIVE  = 2'd2,
        CMD_TRANSMIT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CODE_STANDBY   = 3'd0,
        CODE_CADWAIT   = 3'd1,
        CODE_CADDONE   = 3'd2,
        CODE_TXWAIT    = 3'd3,
        CODE_TXDONE    = 3'd4,
        CODE_RXWAIT    = 3'd5,
        CODE_RXDONE    = 3'd6,
        CODE_RXTIMEOUT = 3'd7
    } state_code_t;

    typedef enum logic [7:0] {
        ST_STANDBY   = 8'b0000_0001,
        ST_CADWAIT   = 8'b0000_0010,
        ST_CADDONE   = 8'b0000_0100,
        ST_TXWAIT    = 8'b0000_1000,
        ST_TXDONE    = 8'b0001_0000,
        ST_RXWAIT    = 8'b0010_0000,
        ST_RXDONE    = 8'b0100_0000,
        ST_RXTIMEOUT = 8'b1000_0000
    } mac_state_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        kind_t kind;
        logic  queue_nonempty;
        logic  head_important;
        logic  tick_20ms;
    } item_t;

    typedef struct packed {
        cmd_t        radio_command;
        logic        pop_packet;
        logic        deliver_message;
        logic        announce_first;
        logic        announce_second;
        state_code_t radio_state;
    } result_t;

    function automatic state_code_t state_code(input mac_state_t st);
        state_code_t code;
        unique case (st)
            ST_STANDBY:   code = CODE_STANDBY;
            ST_CADWAIT:   code = CODE_CADWAIT;
            ST_CADDONE:   code = CODE_CADDONE;
            ST_TXWAIT:    code = CODE_TXWAIT;
            ST_TXDONE:    code = CODE_TXDONE;
            ST_RXWAIT:    code = CODE_RXWAIT;
            ST_RXDONE:    code = CODE_RXDONE;
            ST_RXTIMEOUT: code = CODE_RXTIMEOUT;
            default:      code = CODE_STANDBY;
        endcase
        return code;
    endfunction

endpackage

/* src/lbt_if.sv */
// Interfaces: event channel and result channel with valid/ready handshake.
interface lbt_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic                queue_nonempty;
    logic                head_important;
    logic                tick_20ms;

    modport source (output valid, kind, queue_nonempty, head_important, tick_20ms,
                    input ready);
    modport sink (input valid, kind, queue_nonempty, head_important, tick_20ms,
                  output ready);
endinterface

interface lbt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] radio_command;
    logic       pop_packet;
    logic       deliver_message;
    logic       announce_first;
    logic       announce_second;
    logic [2:0] radio_state;

    modport source (output valid, radio_command, pop_packet, deliver_message,
                    announce_first, announce_second, radio_state,
                    input ready);
    modport sink (input valid, radio_command, pop_packet, deliver_message,
                  announce_first, announce_second, radio_state,
                  output ready);
endinterface

/* src/lbt_seq.sv */
// Sequencer: MAC state, flags, announce countdowns and per-event result logic.
module lbt_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lbt_pkg::DELAY_WIDTH-1:0]   cfg_wr_data,
    input  logic                              accept,
    input  lbt_pkg::item_t                    item,
    output lbt_pkg::result_t                  result
);
    import lbt_pkg::*;

    localparam int SUM_WIDTH = COUNT_WIDTH + DELAY_WIDTH;

    logic [DELAY_WIDTH-1:0] delay_reg;
    mac_state_t             state_reg, state_next;
    logic                   awaiting_reg, awaiting_next;
    logic                   busy_reg, busy_next;
    count_t                 first_reg, first_next;
    count_t                 second_reg, second_next;

    logic [SUM_WIDTH-1:0]   delay_ext;
    logic [SUM_WIDTH-1:0]   second_load;
    cmd_t                   cmd;
    logic                   pop, deliver, ann1, ann2;

    assign delay_ext   = {{COUNT_WIDTH{1'b0}}, delay_reg};
    assign second_load = delay_ext + SUM_WIDTH'(SECOND_OFFSET);

    always_comb
    begin
        state_next    = state_reg;
        awaiting_next = awaiting_reg;
        busy_next     = busy_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        cmd           = CMD_NONE;
        pop           = 1'b0;
        deliver       = 1'b0;
        ann1          = 1'b0;
        ann2          = 1'b0;
        unique case (item.kind)
            KIND_START:
            begin
                first_next  = delay_ext[COUNT_WIDTH-1:0];
                second_next = second_load[COUNT_WIDTH-1:0];
            end
            KIND_LOOP:
            begin
                unique case (state_reg)
                    ST_STANDBY:
                    begin
                        if (!awaiting_reg && item.queue_nonempty)
                        begin
                            state_next = ST_CADWAIT;
                            cmd        = CMD_DETECT;
                        end
                        else
                        begin
                            state_next = ST_RXWAIT;
                            cmd        = CMD_RECEIVE;
                        end
                    end
                    ST_CADDONE:
                    begin
                        if (!busy_reg)
                        begin
                            pop        = 1'b1;
                            cmd        = CMD_TRANSMIT;
                            state_next = ST_TXWAIT;
                            if (item.head_important)
                            begin
                                awaiting_next = 1'b1;
                            end
                        end
                        else
                        begin
                            busy_next  = 1'b0;
                            cmd        = CMD_DETECT;
                            state_next = ST_CADWAIT;
                        end
                    end
                    ST_TXDONE:
                    begin
                        state_next = ST_STANDBY;
                    end
                    ST_RXDONE:
                    begin
                        deliver       = 1'b1;
                        state_next    = ST_STANDBY;
                        awaiting_next = 1'b0;
                    end
                    ST_RXTIMEOUT:
                    begin
                        state_next    = ST_STANDBY;
                        awaiting_next = 1'b0;
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
                if (item.tick_20ms)
                begin
                    if (first_reg != '0)
                    begin
                        first_next = first_reg - 1'b1;
                        ann1       = (first_reg == count_t'(1));
                    end
                    if (second_reg != '0)
                    begin
                        second_next = second_reg - 1'b1;
                        ann2        = (second_reg == count_t'(1));
                    end
                end
            end
            KIND_DONE:
            begin
                priority if (state_reg == ST_RXWAIT)
                begin
                    state_next = ST_RXDONE;
                end
                else if (state_reg == ST_TXWAIT)
                begin
                    state_next = ST_TXDONE;
                end
                else if (state_reg == ST_CADWAIT)
                begin
                    state_next = ST_CADDONE;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            KIND_TIMEOUT:
            begin
                priority if (state_reg == ST_RXWAIT)
                begin
                    state_next = ST_RXTIMEOUT;
                end
                else if (state_reg == ST_CADWAIT)
                begin
                    state_next = ST_CADDONE;
                    busy_next  = 1'b1;
                end
                else if (state_reg == ST_CADDONE)
                begin
                    busy_next = 1'b1;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_comb
    begin
        result.radio_command   = cmd;
        result.pop_packet      = pop;
        result.deliver_message = deliver;
        result.announce_first  = ann1;
        result.announce_second = ann2;
        result.radio_state     = state_code(state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= '0;
            state_reg    <= ST_STANDBY;
            awaiting_reg <= 1'b0;
            busy_reg     <= 1'b0;
            first_reg    <= '0;
            second_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delay_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                state_reg    <= state_next;
                awaiting_reg <= awaiting_next;
                busy_reg     <= busy_next;
                first_reg    <= first_next;
                second_reg   <= second_next;
            end
        end
    end

endmodule

/* src/lbt_out_buf.sv */
// Output stage: result register plus skid register toward the result channel.
module lbt_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lbt_pkg::result_t push_data,
    output logic             push_ready,
    lbt_out_if.source        out_ch
);
    import lbt_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;
    logic    drain;

    assign push_ready = !skid_valid_reg;
    assign drain      = out_valid_reg && out_ch.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push && (!out_valid_reg || drain))
        begin
            out_valid_next = 1'b1;
            out_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
        else if (drain)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.radio_command   = 2'(out_data_reg.radio_command);
    assign out_ch.pop_packet      = out_data_reg.pop_packet;
    assign out_ch.deliver_message = out_data_reg.deliver_message;
    assign out_ch.announce_first  = out_data_reg.announce_first;
    assign out_ch.announce_second = out_data_reg.announce_second;
    assign out_ch.radio_state     = 3'(out_data_reg.radio_state);

endmodule

/* src/radio_listen_before_talk_mac.sv */
// Top level: listen-before-talk radio MAC sequencer.
// Each event (start, loop pass, done interrupt, timeout/detect interrupt)
// yields exactly one result transaction; events may arrive back to back,
// one per clock, while the event channel is ready. The state update and
// result logic sit between the event handshake and a result register, so
// a result is registered before it appears on the result channel. A skid
// register keeps the event channel ready for one more event while a result
// waits; the event channel drops ready only when both result slots are full.
// The announce_delay register is written through cfg_wr_en/cfg_wr_data and
// takes effect at the next start event, which loads the first countdown with
// it and the second with it plus 25 ticks.
module radio_listen_before_talk_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lbt_pkg::DELAY_WIDTH-1:0] cfg_wr_data,
    lbt_in_if.sink                          in_ch,
    lbt_out_if.source                       out_ch
);
    import lbt_pkg::*;

    logic    accept;
    logic    buf_ready;
    item_t   item;
    result_t result;

    assign in_ch.ready = buf_ready;
    assign accept      = in_ch.valid && buf_ready;

    always_comb
    begin
        item.kind           = kind_t'(in_ch.kind);
        item.queue_nonempty = in_ch.queue_nonempty;
        item.head_important = in_ch.head_important;
        item.tick_20ms      = in_ch.tick_20ms;
    end

    lbt_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (item),
        .result      (result)
    );

    lbt_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .push_ready (buf_ready),
        .out_ch     (out_ch)
    );

endmodule

/* src/lbt_checker.sv */
// Checker: port-level properties of the radio MAC, bound to the top level.
module lbt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] radio_command,
    input logic       pop_packet,
    input logic       deliver_message,
    input logic       announce_first,
    input logic       announce_second,
    input logic [2:0] radio_state
);
    import lbt_pkg::*;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(radio_command)
            && $stable(radio_state) && $stable(pop_packet))
        else $error("stalled result transaction changed");

    a_pop_is_transmit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pop_packet |-> radio_command == 2'(CMD_TRANSMIT)
            && radio_state == 3'(CODE_TXWAIT))
        else $error("pop without transmit into txwait");

    a_deliver_to_standby: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && deliver_message |-> radio_command == 2'(CMD_NONE)
            && radio_state == 3'(CODE_STANDBY))
        else $error("deliver outside rxdone exit");

    a_one_announce: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(announce_first && announce_second))
        else $error("both announces in one transaction");

endmodule

bind radio_listen_before_talk_mac lbt_checker u_lbt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .radio_command   (out_ch.radio_command),
    .pop_packet      (out_ch.pop_packet),
    .deliver_message (out_ch.deliver_message),
    .announce_first  (out_ch.announce_first),
    .announce_second (out_ch.announce_second),
    .radio_state     (out_ch.radio_state)
);
